>>> sv/tfnh_pkg.sv
// tfnh_pkg: shared codes for the trace-free neo-Hookean stress pipeline.
// No dependencies; used by the top level and the port checker.
package tfnh_pkg;

	localparam int STATUS_W = 2;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 2'd0,
		ST_SAT     = 2'd1,
		ST_INVALID = 2'd2
	} status_t;

	// register select bit of paddr (word index)
	localparam logic REG_SHEAR = 1'b0;

endpackage

>>> sv/tfnh_wmul.sv
// tfnh_wmul: two-stage signed multiplier for a wide operand times a narrow one.
// Splits the wide operand into chunks; partial products, then one summing stage.
// No package dependencies.
module tfnh_wmul #(
	parameter int WA = 65,
	parameter int WB = 32,
	parameter int CW = 32
) (
	input  logic                    clk,
	input  logic signed [WA-1:0]    a,
	input  logic signed [WB-1:0]    b,
	output logic signed [WA+WB-1:0] p
);

	localparam int NC = (WA + CW - 1) / CW;
	localparam int AE = NC * CW;
	localparam int PW = CW + 1 + WB;
	localparam int SW = AE + WB + 1;

	logic signed [AE-1:0]    a_ext;
	logic signed [PW-1:0]    pp_s1 [NC];
	logic signed [SW-1:0]    acc;
	logic signed [WA+WB-1:0] p_s2;

	assign a_ext = AE'(a);

	for (genvar c = 0; c < NC; c++) begin : g_chunk
		logic signed [CW:0] chunk;
		// only the top chunk carries the sign
		if (c == NC - 1) begin : g_top
			assign chunk = {a_ext[c*CW+CW-1], a_ext[c*CW +: CW]};
		end else begin : g_low
			assign chunk = {1'b0, a_ext[c*CW +: CW]};
		end
		always_ff @(posedge clk) begin
			pp_s1[c] <= chunk * b;
		end
	end

	always_comb begin
		acc = '0;
		for (int c = 0; c < NC; c++) begin
			acc = acc + (SW'(pp_s1[c]) <<< (c * CW));
		end
	end

	always_ff @(posedge clk) begin
		p_s2 <= (WA+WB)'(acc);
	end

	assign p = p_s2;

endmodule

>>> sv/tfnh_div.sv
// tfnh_div: pipelined restoring divider for one stress component, one quotient
// bit per stage, with round-half-away and saturation. No package dependencies.
module tfnh_div #(
	parameter int NW = 149,
	parameter int DW = 133,
	parameter int QW = 32
) (
	input  logic                 clk,
	input  logic [NW-1:0]        mag,
	input  logic                 neg,
	input  logic [DW-1:0]        den,
	output logic signed [QW-1:0] quo,
	output logic                 sat
);

	localparam int RW = ((NW > DW + QW) ? NW : DW + QW) + 1;

	logic [NW-1:0] rem_s [QW+1];
	logic [QW-1:0] quo_s [QW+1];
	logic [DW-1:0] den_s [QW+1];
	logic          neg_s [QW+1];
	logic          ovf_s [QW+1];

	logic [QW:0]          mag_rs;
	logic                 neg_rs, ovf_rs;
	logic signed [QW-1:0] quo_q;
	logic                 sat_q;

	localparam logic [QW:0] HALF = (QW+1)'(1) << (QW - 1);

	// quotient of 2^QW or more saturates in either direction
	always_ff @(posedge clk) begin
		rem_s[0] <= mag;
		quo_s[0] <= '0;
		den_s[0] <= den;
		neg_s[0] <= neg;
		ovf_s[0] <= RW'(mag) >= (RW'(den) << QW);
	end

	for (genvar i = 0; i < QW; i++) begin : g_step
		logic [RW-1:0] sh;
		logic          ge;
		assign sh = RW'(den_s[i]) << (QW - 1 - i);
		assign ge = RW'(rem_s[i]) >= sh;
		always_ff @(posedge clk) begin
			rem_s[i+1] <= ge ? NW'(RW'(rem_s[i]) - sh) : rem_s[i];
			quo_s[i+1] <= {quo_s[i][QW-2:0], ge};
			den_s[i+1] <= den_s[i];
			neg_s[i+1] <= neg_s[i];
			ovf_s[i+1] <= ovf_s[i];
		end
	end

	always_ff @(posedge clk) begin
		mag_rs <= (QW+1)'(quo_s[QW])
			+ (QW+1)'((RW'(rem_s[QW]) << 1) >= RW'(den_s[QW]));
		neg_rs <= neg_s[QW];
		ovf_rs <= ovf_s[QW];
	end

	always_ff @(posedge clk) begin
		if (neg_rs) begin
			if (ovf_rs || mag_rs > HALF) begin
				quo_q <= {1'b1, {(QW-1){1'b0}}};
				sat_q <= 1'b1;
			end else begin
				quo_q <= QW'((QW+1)'(0) - mag_rs);
				sat_q <= 1'b0;
			end
		end else begin
			if (ovf_rs || mag_rs >= HALF) begin
				quo_q <= {1'b0, {(QW-1){1'b1}}};
				sat_q <= 1'b1;
			end else begin
				quo_q <= QW'(mag_rs);
				sat_q <= 1'b0;
			end
		end
	end

	assign quo = quo_q;
	assign sat = sat_q;

endmodule

>>> sv/trace_free_neo_hookean_stress.sv
// trace_free_neo_hookean_stress: pipelined Cauchy / second Piola-Kirchhoff stress.
// Depends on tfnh_pkg, tfnh_wmul and tfnh_div.
//
//  channel   handshake              payload
//  config    psel/penable/pwrite    paddr, pwdata, prdata (shear_modulus)
//  input     start (busy low)       action, t_xx..t_xz, volume_ratio
//  result    done, one cycle        s_xx..s_xz, status
//
// One word enters every cycle; busy stays low. A result passes the adjugate,
// determinant and numerator multiplier stages and then the bit-per-stage
// divider of each component. Reset clears the valid bits and returns
// shear_modulus to 1.0. Nothing stalls: results leave as they are produced.
module trace_free_neo_hookean_stress #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   psel,
	input  logic                                   penable,
	input  logic                                   pwrite,
	input  logic [2:0]                             paddr,
	input  logic [((DATA_WIDTH > 32) ? 64 : 32)-1:0] pwdata,
	output logic [((DATA_WIDTH > 32) ? 64 : 32)-1:0] prdata,
	output logic                                   pready,
	input  logic                                   start,
	output logic                                   busy,
	input  logic                                   action,
	input  logic signed [DATA_WIDTH-1:0]           t_xx,
	input  logic signed [DATA_WIDTH-1:0]           t_yy,
	input  logic signed [DATA_WIDTH-1:0]           t_zz,
	input  logic signed [DATA_WIDTH-1:0]           t_xy,
	input  logic signed [DATA_WIDTH-1:0]           t_yz,
	input  logic signed [DATA_WIDTH-1:0]           t_xz,
	input  logic signed [DATA_WIDTH-1:0]           volume_ratio,
	output logic                                   done,
	output logic signed [DATA_WIDTH-1:0]           s_xx,
	output logic signed [DATA_WIDTH-1:0]           s_yy,
	output logic signed [DATA_WIDTH-1:0]           s_zz,
	output logic signed [DATA_WIDTH-1:0]           s_xy,
	output logic signed [DATA_WIDTH-1:0]           s_yz,
	output logic signed [DATA_WIDTH-1:0]           s_xz,
	output logic [tfnh_pkg::STATUS_W-1:0]          status
);

	localparam int PDW     = (DATA_WIDTH > 32) ? 64 : 32;
	localparam int DW      = DATA_WIDTH;
	localparam int TW      = DW + 2;
	localparam int AW      = 2 * DW + 1;
	localparam int DTW     = 3 * DW + 3;
	localparam int CNW     = DW + 3;
	localparam int NUMW    = 3 * DW + 6;
	localparam int DENW    = 4 * DW + 5;
	localparam int PRODW   = NUMW + DW + FRAC_BITS;
	localparam int DIV_LAT = DW + 3;

	// adjugate product operands, t order xx yy zz xy yz xz
	localparam int PA [12] = '{1, 4, 0, 5, 0, 3, 5, 3, 3, 0, 3, 5};
	localparam int PB [12] = '{2, 4, 2, 5, 1, 3, 4, 2, 5, 4, 4, 1};
	localparam int DI [3]  = '{0, 3, 5};

	// configuration
	logic [DW-2:0]        mu_q;
	logic signed [DW-1:0] mu_sg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mu_q <= (DW-1)'(64'd1 << FRAC_BITS);
		end else if (psel && penable && pwrite && paddr[2] == tfnh_pkg::REG_SHEAR) begin
			mu_q <= pwdata[DW-2:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == tfnh_pkg::REG_SHEAR) ? PDW'(mu_q) : '0;
	assign busy   = 1'b0;
	assign mu_sg  = {1'b0, mu_q};

	logic signed [DW-1:0] t_in [6];
	assign t_in[0] = t_xx;
	assign t_in[1] = t_yy;
	assign t_in[2] = t_zz;
	assign t_in[3] = t_xy;
	assign t_in[4] = t_yz;
	assign t_in[5] = t_xz;

	// valid chain
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;
	logic vld_sd [DIV_LAT];
	logic done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
			for (int i = 0; i < DIV_LAT; i++) vld_sd[i] <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
			vld_sd[0] <= v_s9;
			for (int i = 1; i < DIV_LAT; i++) vld_sd[i] <= vld_sd[i-1];
			done_q <= vld_sd[DIV_LAT-1];
		end
	end

	// stage 1: trace and the twelve adjugate products
	logic                   act_s1;
	logic signed [DW-1:0]   t_s1 [6];
	logic signed [DW-1:0]   j_s1;
	logic signed [TW-1:0]   tr_s1;
	logic signed [2*DW-1:0] pp_s1 [12];

	always_ff @(posedge clk) begin
		act_s1 <= action;
		j_s1   <= volume_ratio;
		tr_s1  <= TW'(t_in[0]) + TW'(t_in[1]) + TW'(t_in[2]);
		for (int k = 0; k < 6; k++) t_s1[k] <= t_in[k];
		for (int i = 0; i < 12; i++) pp_s1[i] <= t_in[PA[i]] * t_in[PB[i]];
	end

	// stage 2: adjugate, Cauchy numerators and denominator, divisor checks
	logic                    act_s2, bad_s2;
	logic signed [DW-1:0]    t_s2 [6];
	logic signed [TW-1:0]    tr_s2;
	logic signed [AW-1:0]    adj_s2 [6];
	logic signed [CNW-1:0]   cnum_s2 [6];
	logic signed [TW+DW-1:0] cden_s2;

	always_ff @(posedge clk) begin
		act_s2  <= act_s1;
		bad_s2  <= (tr_s1 <= 0) || (!act_s1 && j_s1 <= 0);
		tr_s2   <= tr_s1;
		cden_s2 <= tr_s1 * j_s1;
		for (int k = 0; k < 6; k++) begin
			t_s2[k]   <= t_s1[k];
			adj_s2[k] <= AW'(pp_s1[2*k]) - AW'(pp_s1[2*k+1]);
			if (k < 3) begin
				cnum_s2[k] <= (CNW'(t_s1[k]) <<< 1) + CNW'(t_s1[k]) - CNW'(tr_s1);
			end else begin
				cnum_s2[k] <= (CNW'(t_s1[k]) <<< 1) + CNW'(t_s1[k]);
			end
		end
	end

	// stages 3-4: determinant terms and adj*tr
	logic signed [AW+DW-1:0] dp_w [3];
	logic signed [AW+TW-1:0] at_w [6];

	for (genvar g = 0; g < 3; g++) begin : g_det
		tfnh_wmul #(.WA(AW), .WB(DW), .CW(DW)) u_mul (
			.clk (clk),
			.a   (adj_s2[DI[g]]),
			.b   (t_s2[DI[g]]),
			.p   (dp_w[g])
		);
	end

	for (genvar g = 0; g < 6; g++) begin : g_at
		tfnh_wmul #(.WA(AW), .WB(TW), .CW(DW)) u_mul (
			.clk (clk),
			.a   (adj_s2[g]),
			.b   (tr_s2),
			.p   (at_w[g])
		);
	end

	logic                    act_s3, act_s4, bad_s3, bad_s4;
	logic signed [TW-1:0]    tr_s3, tr_s4;
	logic signed [TW+DW-1:0] cden_s3, cden_s4;
	logic signed [CNW-1:0]   cnum_s3 [6];
	logic signed [CNW-1:0]   cnum_s4 [6];

	always_ff @(posedge clk) begin
		act_s3  <= act_s2;
		act_s4  <= act_s3;
		bad_s3  <= bad_s2;
		bad_s4  <= bad_s3;
		tr_s3   <= tr_s2;
		tr_s4   <= tr_s3;
		cden_s3 <= cden_s2;
		cden_s4 <= cden_s3;
		for (int k = 0; k < 6; k++) begin
			cnum_s3[k] <= cnum_s2[k];
			cnum_s4[k] <= cnum_s3[k];
		end
	end

	// stage 5: determinant
	logic                    act_s5, bad_s5;
	logic signed [DTW-1:0]   det_s5;
	logic signed [TW-1:0]    tr_s5;
	logic signed [TW+DW-1:0] cden_s5;
	logic signed [AW+TW-1:0] at_s5 [6];
	logic signed [CNW-1:0]   cnum_s5 [6];

	always_ff @(posedge clk) begin
		act_s5  <= act_s4;
		bad_s5  <= bad_s4;
		tr_s5   <= tr_s4;
		cden_s5 <= cden_s4;
		det_s5  <= DTW'(dp_w[0]) + DTW'(dp_w[1]) + DTW'(dp_w[2]);
		for (int k = 0; k < 6; k++) begin
			at_s5[k]   <= at_w[k];
			cnum_s5[k] <= cnum_s4[k];
		end
	end

	// stage 6: select the numerator of the chosen stress
	logic signed [NUMW-1:0]  det3;
	logic signed [NUMW-1:0]  num_c [6];
	logic                    act_s6, bad_s6;
	logic signed [DTW-1:0]   det_s6;
	logic signed [TW-1:0]    tr_s6;
	logic signed [TW+DW-1:0] cden_s6;
	logic signed [NUMW-1:0]  num_s6 [6];

	assign det3 = (NUMW'(det_s5) <<< 1) + NUMW'(det_s5);

	always_comb begin
		for (int k = 0; k < 6; k++) begin
			if (!act_s5) begin
				num_c[k] = NUMW'(cnum_s5[k]);
			end else if (k < 3) begin
				num_c[k] = det3 - NUMW'(at_s5[k]);
			end else begin
				num_c[k] = -NUMW'(at_s5[k]);
			end
		end
	end

	always_ff @(posedge clk) begin
		act_s6  <= act_s5;
		bad_s6  <= bad_s5 || (act_s5 && det_s5 <= 0);
		det_s6  <= det_s5;
		tr_s6   <= tr_s5;
		cden_s6 <= cden_s5;
		for (int k = 0; k < 6; k++) num_s6[k] <= num_c[k];
	end

	// stages 7-8: second Piola-Kirchhoff denominator and mu * numerator
	logic signed [DENW-1:0]    sden_w;
	logic signed [NUMW+DW-1:0] nm_w [6];

	tfnh_wmul #(.WA(DTW), .WB(TW), .CW(DW)) u_den_mul (
		.clk (clk),
		.a   (det_s6),
		.b   (tr_s6),
		.p   (sden_w)
	);

	for (genvar g = 0; g < 6; g++) begin : g_nm
		tfnh_wmul #(.WA(NUMW), .WB(DW), .CW(DW)) u_mul (
			.clk (clk),
			.a   (num_s6[g]),
			.b   (mu_sg),
			.p   (nm_w[g])
		);
	end

	logic                    act_s7, act_s8, bad_s7, bad_s8;
	logic signed [TW+DW-1:0] cden_s7, cden_s8;

	always_ff @(posedge clk) begin
		act_s7  <= act_s6;
		act_s8  <= act_s7;
		bad_s7  <= bad_s6;
		bad_s8  <= bad_s7;
		cden_s7 <= cden_s6;
		cden_s8 <= cden_s7;
	end

	// stage 9: magnitude and sign for the dividers
	logic signed [PRODW-1:0] prod_c [6];
	logic [PRODW-1:0]        mag_s9 [6];
	logic                    neg_s9 [6];
	logic [DENW-1:0]         den_s9;
	logic                    bad_s9;

	always_comb begin
		for (int k = 0; k < 6; k++) begin
			prod_c[k] = PRODW'(nm_w[k]) <<< FRAC_BITS;
		end
	end

	always_ff @(posedge clk) begin
		bad_s9 <= bad_s8;
		den_s9 <= act_s8 ? sden_w : DENW'(cden_s8);
		for (int k = 0; k < 6; k++) begin
			neg_s9[k] <= prod_c[k][PRODW-1];
			mag_s9[k] <= prod_c[k][PRODW-1] ? PRODW'(-prod_c[k]) : PRODW'(prod_c[k]);
		end
	end

	// dividers
	logic signed [DW-1:0] quo_w [6];
	logic                 sat_w [6];

	for (genvar g = 0; g < 6; g++) begin : g_div
		tfnh_div #(.NW(PRODW), .DW(DENW), .QW(DW)) u_div (
			.clk (clk),
			.mag (mag_s9[g]),
			.neg (neg_s9[g]),
			.den (den_s9),
			.quo (quo_w[g]),
			.sat (sat_w[g])
		);
	end

	logic bad_sd [DIV_LAT];

	always_ff @(posedge clk) begin
		bad_sd[0] <= bad_s9;
		for (int i = 1; i < DIV_LAT; i++) bad_sd[i] <= bad_sd[i-1];
	end

	// output register: an invalid divisor zeroes the stress
	logic signed [DW-1:0]         res_q [6];
	logic [tfnh_pkg::STATUS_W-1:0] status_q;
	logic                          any_sat;

	always_comb begin
		any_sat = 1'b0;
		for (int k = 0; k < 6; k++) any_sat = any_sat | sat_w[k];
	end

	always_ff @(posedge clk) begin
		if (bad_sd[DIV_LAT-1]) begin
			for (int k = 0; k < 6; k++) res_q[k] <= '0;
			status_q <= tfnh_pkg::ST_INVALID;
		end else begin
			for (int k = 0; k < 6; k++) res_q[k] <= quo_w[k];
			status_q <= any_sat ? tfnh_pkg::ST_SAT : tfnh_pkg::ST_OK;
		end
	end

	assign done   = done_q;
	assign s_xx   = res_q[0];
	assign s_yy   = res_q[1];
	assign s_zz   = res_q[2];
	assign s_xy   = res_q[3];
	assign s_yz   = res_q[4];
	assign s_xz   = res_q[5];
	assign status = status_q;

endmodule

>>> sv/tfnh_check.sv
// tfnh_check: port-level checks for the stress pipeline, bound to the top level.
// Depends on tfnh_pkg.
module tfnh_check #(
	parameter int DATA_WIDTH = 32
) (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  start,
	input logic                                  busy,
	input logic                                  done,
	input logic [tfnh_pkg::STATUS_W-1:0]         status,
	input logic signed [DATA_WIDTH-1:0]          s_xx,
	input logic signed [DATA_WIDTH-1:0]          s_yy,
	input logic signed [DATA_WIDTH-1:0]          s_zz,
	input logic signed [DATA_WIDTH-1:0]          s_xy,
	input logic signed [DATA_WIDTH-1:0]          s_yz,
	input logic signed [DATA_WIDTH-1:0]          s_xz
);

	localparam int LAT = DATA_WIDTH + 13;

	a_word_result: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LAT done)
		else $error("accepted word produced no result");

	a_result_word: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result without an accepted word");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == tfnh_pkg::ST_INVALID |->
			s_xx == 0 && s_yy == 0 && s_zz == 0 && s_xy == 0 && s_yz == 0 && s_xz == 0)
		else $error("invalid result carries nonzero stress");

endmodule

bind trace_free_neo_hookean_stress tfnh_check #(.DATA_WIDTH(DATA_WIDTH)) u_check (.*);
